// ===== rtl/esc_pkg.sv =====
// Package with item types, codes and fixed-point helpers for the compensation unit.
package esc_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 48;
    localparam int WordW    = 64;
    localparam int PcW      = 5;

    localparam logic [1:0] OP_TEMP  = 2'd0;
    localparam logic [1:0] OP_PRESS = 2'd1;
    localparam logic [1:0] OP_HUM   = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_TEMP    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_A = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_B = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_C = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_HUM_A   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_HUM_B   = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [19:0] raw_reading;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] measurement;
        logic               fault;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        K_ALU,
        K_MUL,
        K_DIV,
        K_END
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [1:0]        dst;
        logic [WordW-1:0]  val;
        logic [WordW-1:0]  x;
        logic [WordW-1:0]  y;
        logic              set_fine;
        logic              fault;
    } t_step;

    function automatic logic [63:0] f_sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] f_sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] f_sra(input logic [63:0] v, input int k);
        return 64'($signed(v) >>> k);
    endfunction

    function automatic logic [31:0] f_sdivp2(input logic [31:0] v, input int k);
        logic [31:0] t;
        t = v + (v[31] ? ((32'd1 << k) - 32'd1) : 32'd0);
        return 32'($signed(t) >>> k);
    endfunction

endpackage

// ===== rtl/env_sensor_compensation_unit.sv =====
// Top level: step sequencer with working registers, serial multiplier and divider.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_in_data  (opcode, raw_reading)
//  out      output     o_out_valid / i_out_ready o_out_data (measurement, fault)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item at a time runs through a short step program; each multiply and the pressure
// division are issued from the step state and then finish in their serial units.
// Reset clears the coefficients, the fine temperature and all control state.
// A result waiting in the output register holds the sequencer in its final step.
module env_sensor_compensation_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  esc_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output esc_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [esc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [esc_pkg::CfgDataW-1:0] i_cfg_data
);
    import esc_pkg::*;

    t_state       r_state, n_state;
    logic [PcW-1:0] r_pc, n_pc;
    t_in_item     r_item;
    logic [63:0]  r_regs [4];
    logic [31:0]  r_fine;
    logic [47:0]  r_temp, r_pa, r_pb, r_pc_coef;
    logic [31:0]  r_ha;
    logic [39:0]  r_hb;
    t_out_item    r_out, r_res;
    logic         r_out_valid;
    t_step        st;
    logic         mul_start, mul_done, div_start, div_done;
    logic [63:0]  mul_prod, div_quo;
    logic [63:0]  r0, r1, r2, r3;
    logic [63:0]  t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0]  h1, h2, h3, h4, h5, h6;
    logic [19:0]  raw;
    logic [31:0]  hv;

    assign r0 = r_regs[0];
    assign r1 = r_regs[1];
    assign r2 = r_regs[2];
    assign r3 = r_regs[3];
    assign raw = r_item.raw_reading;

    assign t1 = {48'd0, r_temp[15:0]};
    assign t2 = f_sx16(r_temp[31:16]);
    assign t3 = f_sx16(r_temp[47:32]);
    assign p1 = {48'd0, r_pa[15:0]};
    assign p2 = f_sx16(r_pa[31:16]);
    assign p3 = f_sx16(r_pa[47:32]);
    assign p4 = f_sx16(r_pb[15:0]);
    assign p5 = f_sx16(r_pb[31:16]);
    assign p6 = f_sx16(r_pb[47:32]);
    assign p7 = f_sx16(r_pc_coef[15:0]);
    assign p8 = f_sx16(r_pc_coef[31:16]);
    assign p9 = f_sx16(r_pc_coef[47:32]);
    assign h1 = {56'd0, r_ha[7:0]};
    assign h2 = f_sx16(r_ha[23:8]);
    assign h3 = {56'd0, r_ha[31:24]};
    assign h4 = f_sx16(r_hb[15:0]);
    assign h5 = f_sx16(r_hb[31:16]);
    assign h6 = {{56{r_hb[39]}}, r_hb[39:32]};

    always_comb begin
        st = '{kind: K_END, dst: 2'd0, val: '0, x: '0, y: '0, set_fine: 1'b0, fault: 1'b0};
        hv = r1[31:0];
        unique case (r_item.opcode)
            OP_TEMP: begin
                unique case (r_pc)
                    5'd0: begin st.kind = K_ALU; st.dst = 2'd0;
                        st.val = 64'(raw[19:3]) - {t1[62:0], 1'b0}; end
                    5'd1: begin st.kind = K_ALU; st.dst = 2'd1;
                        st.val = 64'(raw[19:4]) - t1; end
                    5'd2: begin st.kind = K_MUL; st.dst = 2'd0; st.x = r0; st.y = t2; end
                    5'd3: begin st.kind = K_MUL; st.dst = 2'd1; st.x = r1; st.y = r1; end
                    5'd4: begin st.kind = K_ALU; st.dst = 2'd1; st.val = f_sra(r1, 12); end
                    5'd5: begin st.kind = K_MUL; st.dst = 2'd1; st.x = r1; st.y = t3; end
                    5'd6: begin st.kind = K_ALU; st.dst = 2'd0; st.set_fine = 1'b1;
                        st.val = f_sra(r0, 11) + f_sra(r1, 14); end
                    5'd7: begin st.kind = K_ALU; st.dst = 2'd0;
                        st.val = {r0[61:0], 2'b00} + r0 + 64'd128; end
                    default: begin st.kind = K_END; st.val = f_sra(r0, 8); end
                endcase
            end
            OP_PRESS: begin
                unique case (r_pc)
                    5'd0: begin st.kind = K_ALU; st.dst = 2'd0;
                        st.val = f_sx32(r_fine) - 64'd128000; end
                    5'd1: begin st.kind = K_MUL; st.dst = 2'd1; st.x = r0; st.y = r0; end
                    5'd2: begin st.kind = K_MUL; st.dst = 2'd2; st.x = r1; st.y = p6; end
                    5'd3: begin st.kind = K_MUL; st.dst = 2'd3; st.x = r0; st.y = p5; end
                    5'd4: begin st.kind = K_ALU; st.dst = 2'd2;
                        st.val = r2 + {r3[46:0], 17'd0} + {p4[28:0], 35'd0}; end
                    5'd5: begin st.kind = K_MUL; st.dst = 2'd1; st.x = r1; st.y = p3; end
                    5'd6: begin st.kind = K_MUL; st.dst = 2'd3; st.x = r0; st.y = p2; end
                    5'd7: begin st.kind = K_ALU; st.dst = 2'd0;
                        st.val = f_sra(r1, 8) + {r3[51:0], 12'd0}; end
                    5'd8: begin st.kind = K_ALU; st.dst = 2'd0;
                        st.val = (64'd1 << 47) + r0; end
                    5'd9: begin st.kind = K_MUL; st.dst = 2'd0; st.x = r0; st.y = p1; end
                    5'd10: begin st.kind = K_ALU; st.dst = 2'd0; st.val = f_sra(r0, 33); end
                    5'd11: begin
                        if (r0 == '0) begin
                            st.kind = K_END; st.fault = 1'b1; st.val = '0;
                        end else begin
                            st.kind = K_ALU; st.dst = 2'd1;
                            st.val = ((64'd1048576 - 64'(raw)) << 31) - r2;
                        end
                    end
                    5'd12: begin st.kind = K_MUL; st.dst = 2'd1; st.x = r1; st.y = 64'd3125; end
                    5'd13: begin st.kind = K_DIV; st.dst = 2'd1; st.x = r1; st.y = r0; end
                    5'd14: begin st.kind = K_ALU; st.dst = 2'd2; st.val = f_sra(r1, 13); end
                    5'd15: begin st.kind = K_MUL; st.dst = 2'd3; st.x = p9; st.y = r2; end
                    5'd16: begin st.kind = K_MUL; st.dst = 2'd3; st.x = r3; st.y = r2; end
                    5'd17: begin st.kind = K_ALU; st.dst = 2'd3; st.val = f_sra(r3, 25); end
                    5'd18: begin st.kind = K_MUL; st.dst = 2'd2; st.x = p8; st.y = r1; end
                    5'd19: begin st.kind = K_ALU; st.dst = 2'd2; st.val = f_sra(r2, 19); end
                    5'd20: begin st.kind = K_ALU; st.dst = 2'd1;
                        st.val = f_sra(r1 + r3 + r2, 8) + {p7[59:0], 4'd0}; end
                    default: begin st.kind = K_END; st.val = r1; end
                endcase
            end
            OP_HUM: begin
                unique case (r_pc)
                    5'd0: begin st.kind = K_ALU; st.dst = 2'd0;
                        st.val = f_sx32(r_fine - 32'd76800); end
                    5'd1: begin st.kind = K_MUL; st.dst = 2'd1; st.x = h5; st.y = r0; end
                    5'd2: begin st.kind = K_ALU; st.dst = 2'd1;
                        st.val = f_sx32(f_sdivp2({2'b00, raw[15:0], 14'd0}
                            - {h4[11:0], 20'd0} - r1[31:0] + 32'd16384, 15)); end
                    5'd3: begin st.kind = K_MUL; st.dst = 2'd2; st.x = r0; st.y = h6; end
                    5'd4: begin st.kind = K_ALU; st.dst = 2'd2;
                        st.val = f_sx32(f_sdivp2(r2[31:0], 10)); end
                    5'd5: begin st.kind = K_MUL; st.dst = 2'd3; st.x = r0; st.y = h3; end
                    5'd6: begin st.kind = K_ALU; st.dst = 2'd3;
                        st.val = f_sx32(f_sdivp2(r3[31:0], 11) + 32'd32768); end
                    5'd7: begin st.kind = K_MUL; st.dst = 2'd2; st.x = r2; st.y = r3; end
                    5'd8: begin st.kind = K_ALU; st.dst = 2'd2;
                        st.val = f_sx32(f_sdivp2(r2[31:0], 10) + 32'd2097152); end
                    5'd9: begin st.kind = K_MUL; st.dst = 2'd2; st.x = r2; st.y = h2; end
                    5'd10: begin st.kind = K_ALU; st.dst = 2'd2;
                        st.val = f_sx32(f_sdivp2(r2[31:0] + 32'd8192, 14)); end
                    5'd11: begin st.kind = K_MUL; st.dst = 2'd1; st.x = r1; st.y = r2; end
                    5'd12: begin st.kind = K_ALU; st.dst = 2'd2;
                        st.val = f_sx32(f_sdivp2(r1[31:0], 15)); end
                    5'd13: begin st.kind = K_MUL; st.dst = 2'd2; st.x = r2; st.y = r2; end
                    5'd14: begin st.kind = K_ALU; st.dst = 2'd2;
                        st.val = f_sx32(f_sdivp2(r2[31:0], 7)); end
                    5'd15: begin st.kind = K_MUL; st.dst = 2'd2; st.x = r2; st.y = h1; end
                    5'd16: begin st.kind = K_ALU; st.dst = 2'd1;
                        st.val = f_sx32(r1[31:0] - f_sdivp2(r2[31:0], 4)); end
                    default: begin
                        st.kind = K_END;
                        if (hv[31]) begin
                            hv = '0;
                        end else if (hv > 32'd419430400) begin
                            hv = 32'd419430400;
                        end
                        st.val = {44'd0, hv[31:12]};
                    end
                endcase
            end
            default: begin st.kind = K_END; st.val = '0; end
        endcase
    end

    assign mul_start = (r_state == S_EXEC) && (st.kind == K_MUL);
    assign div_start = (r_state == S_EXEC) && (st.kind == K_DIV);

    esc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (st.x),
        .i_y     (st.y),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (st.x),
        .i_den   (st.y),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                    n_pc    = '0;
                end
            end
            S_EXEC: begin
                unique case (st.kind)
                    K_ALU: n_pc = r_pc + 1'b1;
                    K_MUL: n_state = S_MUL;
                    K_DIV: n_state = S_DIV;
                    K_END: n_state = S_DONE;
                endcase
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = S_EXEC;
                    n_pc    = r_pc + 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EXEC;
                    n_pc    = r_pc + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
            r_fine      <= '0;
            r_temp      <= '0;
            r_pa        <= '0;
            r_pb        <= '0;
            r_pc_coef   <= '0;
            r_ha        <= '0;
            r_hb        <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EXEC && st.kind == K_ALU && st.set_fine) begin
                r_fine <= st.val[31:0];
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TEMP:    r_temp    <= i_cfg_data;
                    CFG_PRESS_A: r_pa      <= i_cfg_data;
                    CFG_PRESS_B: r_pb      <= i_cfg_data;
                    CFG_PRESS_C: r_pc_coef <= i_cfg_data;
                    CFG_HUM_A:   r_ha      <= i_cfg_data[31:0];
                    CFG_HUM_B:   r_hb      <= i_cfg_data[39:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in_data;
        end
        if (r_state == S_EXEC && st.kind == K_ALU) begin
            r_regs[st.dst] <= st.val;
        end else if (r_state == S_MUL && mul_done) begin
            r_regs[st.dst] <= mul_prod;
        end else if (r_state == S_DIV && div_done) begin
            r_regs[st.dst] <= div_quo;
        end
        if (r_state == S_EXEC && st.kind == K_END) begin
            r_res.measurement <= st.val[31:0];
            r_res.fault       <= st.fault;
        end
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
endmodule

// ===== rtl/esc_mul.sv =====
// Bit-serial shift-and-add multiplier giving the low 64 bits of the product.
module esc_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [63:0]          i_x,
    input  logic [63:0]          i_y,
    output logic                 o_done,
    output logic [63:0]          o_prod
);
    import esc_pkg::*;

    logic        r_busy, n_busy;
    logic [63:0] r_x, n_x, r_y, n_y, r_acc, n_acc;

    always_comb begin
        n_busy = r_busy;
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_x    = i_x;
            n_y    = i_y;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_y == '0) begin
                n_busy = 1'b0;
            end else begin
                n_acc = r_acc + (r_y[0] ? r_x : 64'd0);
                n_x   = {r_x[62:0], 1'b0};
                n_y   = {1'b0, r_y[63:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    assign o_done = r_busy && (r_y == '0);
    assign o_prod = r_acc;
endmodule

// ===== rtl/esc_div.sv =====
// Bit-serial restoring signed divider, 64 bits, truncating toward zero.
module esc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    import esc_pkg::*;

    logic        r_busy, n_busy;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_rem, n_rem, r_quo, n_quo, r_den, n_den;
    logic        r_neg, n_neg;
    logic [64:0] rem_sh, rem_sub;

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        n_neg   = r_neg;
        rem_sh  = {r_rem, r_quo[63]};
        rem_sub = rem_sh - {1'b0, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_num[63] ? (64'd0 - i_num) : i_num;
            n_den  = i_den[63] ? (64'd0 - i_den) : i_den;
            n_neg  = i_num[63] ^ i_den[63];
        end else if (r_busy) begin
            if (r_cnt == 7'd64) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt + 7'd1;
                if (!rem_sub[64]) begin
                    n_rem = rem_sub[63:0];
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = rem_sh[63:0];
                    n_quo = {r_quo[62:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_done = r_busy && (r_cnt == 7'd64);
    assign o_quo  = r_neg ? (64'd0 - r_quo) : r_quo;
endmodule

// ===== rtl/esc_checker.sv =====
// Port-level checker for the compensation unit and its bind statement.
module esc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  esc_pkg::t_out_item o_out_data,
    input  logic               o_cfg_ready
);
    import esc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Output item changed while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input taken while an item is in work.");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.fault |-> o_out_data.measurement == 32'sd0)
        else $error("Faulted item carries a nonzero measurement.");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("Configuration port stalled.");
endmodule

bind env_sensor_compensation_unit esc_checker u_esc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);

// ===== sim/env_sensor_compensation_checker.sv =====
// Checker that predicts each compensated result from the accepted items and compares it.
module env_sensor_compensation_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  esc_pkg::t_in_item            i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  esc_pkg::t_out_item           i_out_data,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [esc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [esc_pkg::CfgDataW-1:0] i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;

    logic [47:0] temp_k, press_ka, press_kb, press_kc;
    logic [31:0] hum_ka;
    logic [39:0] hum_kb;
    logic [31:0] t_fine;
    t_out_item   expected_results[$];

    function automatic logic [63:0] ext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] quot64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [31:0] quot32(input logic [31:0] a, input logic [31:0] d);
        logic [31:0] m;
        m = a[31] ? -a : a;
        m = m / d;
        return a[31] ? -m : m;
    endfunction

    function automatic t_out_item compensate(input logic [1:0] op, input logic [19:0] raw);
        t_out_item r;
        logic [63:0] a, b, v1, v2, p, q, tf;
        logic [31:0] h1, h2, h3, h4, h5, h6, adc, w1, w2, w3, w4, w5, s;
        r = '0;
        case (op)
            OP_TEMP: begin
                a = 64'(raw >> 3) - (64'(temp_k[15:0]) << 1);
                b = 64'(raw >> 4) - 64'(temp_k[15:0]);
                v1 = asr64(a * ext16(temp_k[31:16]), 11);
                v2 = asr64(asr64(b * b, 12) * ext16(temp_k[47:32]), 14);
                tf = v1 + v2;
                t_fine = tf[31:0];
                p = asr64(tf * 64'd5 + 64'd128, 8);
                r.measurement = p[31:0];
            end
            OP_PRESS: begin
                v1 = {{32{t_fine[31]}}, t_fine} - 64'd128000;
                v2 = v1 * v1 * ext16(press_kb[47:32]);
                v2 = v2 + ((v1 * ext16(press_kb[31:16])) << 17);
                v2 = v2 + (ext16(press_kb[15:0]) << 35);
                v1 = asr64(v1 * v1 * ext16(press_ka[47:32]), 8)
                     + ((v1 * ext16(press_ka[31:16])) << 12);
                v1 = asr64(((64'd1 << 47) + v1) * 64'(press_ka[15:0]), 33);
                if (v1 == 64'd0) begin
                    r.fault = 1'b1;
                end else begin
                    p = 64'd1048576 - 64'(raw);
                    p = quot64(((p << 31) - v2) * 64'd3125, v1);
                    q = asr64(p, 13);
                    v1 = asr64(ext16(press_kc[47:32]) * q * q, 25);
                    v2 = asr64(ext16(press_kc[31:16]) * p, 19);
                    p = asr64(p + v1 + v2, 8) + (ext16(press_kc[15:0]) << 4);
                    r.measurement = p[31:0];
                end
            end
            OP_HUM: begin
                h1 = 32'(hum_ka[7:0]);
                h2 = {{16{hum_ka[23]}}, hum_ka[23:8]};
                h3 = 32'(hum_ka[31:24]);
                h4 = {{16{hum_kb[15]}}, hum_kb[15:0]};
                h5 = {{16{hum_kb[31]}}, hum_kb[31:16]};
                h6 = {{24{hum_kb[39]}}, hum_kb[39:32]};
                adc = 32'(raw[15:0]);
                w1 = t_fine - 32'd76800;
                w2 = adc * 32'd16384;
                w3 = h4 * 32'd1048576;
                w4 = h5 * w1;
                w5 = quot32(w2 - w3 - w4 + 32'd16384, 32'd32768);
                w2 = quot32(w1 * h6, 32'd1024);
                w3 = quot32(w1 * h3, 32'd2048);
                w4 = quot32(w2 * (w3 + 32'd32768), 32'd1024) + 32'd2097152;
                w2 = quot32(w4 * h2 + 32'd8192, 32'd16384);
                w3 = w5 * w2;
                s = quot32(w3, 32'd32768);
                w4 = quot32(s * s, 32'd128);
                w5 = w3 - quot32(w4 * h1, 32'd16);
                if (w5[31]) w5 = 32'd0;
                if (w5 > 32'd419430400) w5 = 32'd419430400;
                w5 = w5 / 32'd4096;
                if (w5 > 32'd102400) w5 = 32'd102400;
                r.measurement = w5;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            temp_k = '0;
            press_ka = '0;
            press_kb = '0;
            press_kc = '0;
            hum_ka = '0;
            hum_kb = '0;
            t_fine = '0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEMP:    temp_k = i_cfg_data;
                    CFG_PRESS_A: press_ka = i_cfg_data;
                    CFG_PRESS_B: press_kb = i_cfg_data;
                    CFG_PRESS_C: press_kc = i_cfg_data;
                    CFG_HUM_A:   hum_ka = i_cfg_data[31:0];
                    CFG_HUM_B:   hum_kb = i_cfg_data[39:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(
                    compensate(i_in_data.opcode, i_in_data.raw_reading));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, i_out_data);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.measurement !== i_out_data.measurement) begin
                        $display("%0t: measurement expected %h actual %h", $time,
                                 want.measurement, i_out_data.measurement);
                        o_fail_count++;
                    end
                    if (want.fault !== i_out_data.fault) begin
                        $display("%0t: fault expected %b actual %b", $time,
                                 want.fault, i_out_data.fault);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== sim/env_sensor_compensation_unit_test.sv =====
// Top of the testbench: clock, reset, stimulus, output stalls, watchdog and verdict.
module env_sensor_compensation_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;

    localparam int HoldCycles = 4000;
    localparam int IdleLimit  = 30000;

    localparam logic [47:0] TempStd   = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [47:0] PressAStd = {16'd3024, 16'hD643, 16'd36477};
    localparam logic [47:0] PressBStd = {16'hFFF9, 16'd140, 16'd2855};
    localparam logic [47:0] PressCStd = {16'd6000, 16'hC6F8, 16'd15500};
    localparam logic [47:0] HumAStd   = {16'd0, 8'd0, 16'd362, 8'd75};
    localparam logic [47:0] HumBStd   = {8'd0, 8'd30, 16'd50, 16'd313};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int burst_left;
    int idle_count;
    bit gaps_on;
    bit hold_req;

    env_sensor_compensation_unit dut (.*);

    env_sensor_compensation_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always begin
        int mode;
        mode = $urandom_range(0, 2);
        repeat (100) begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
                hold_req = 1'b0;
            end
            case (mode)
                0: i_out_ready = 1'b1;
                1: i_out_ready = $urandom_range(0, 1);
                default: i_out_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_count = 0;
        end else begin
            idle_count++;
            if (idle_count >= IdleLimit) begin
                $display("env_sensor_compensation_unit_test failed");
                $finish;
            end
        end
    end

    task automatic send_reading(input logic [1:0] op, input logic [19:0] raw);
        if (gaps_on && burst_left == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 20)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data.opcode = op;
        i_in_data.raw_reading = raw;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (pending == 0);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [47:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_coeffs(input logic [47:0] t, input logic [47:0] pa,
                               input logic [47:0] pb, input logic [47:0] pc,
                               input logic [47:0] ha, input logic [47:0] hb);
        drain();
        write_reg(CFG_TEMP, t);
        write_reg(CFG_PRESS_A, pa);
        write_reg(CFG_PRESS_B, pb);
        write_reg(CFG_PRESS_C, pc);
        write_reg(CFG_HUM_A, ha);
        write_reg(CFG_HUM_B, hb);
    endtask

    function automatic logic [19:0] pick_raw(input logic [1:0] op);
        if ($urandom_range(0, 1)) return 20'($urandom_range(0, 20'hFFFFF));
        case (op)
            OP_TEMP:  return 20'($urandom_range(400000, 600000));
            OP_PRESS: return 20'($urandom_range(250000, 450000));
            default:  return {4'($urandom), 16'($urandom_range(20000, 40000))};
        endcase
    endfunction

    function automatic logic [47:0] rnd48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic random_readings(input int n);
        logic [1:0] op;
        int sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 7) begin
                send_reading(OP_TEMP, pick_raw(OP_TEMP));
                send_reading(OP_PRESS, pick_raw(OP_PRESS));
                send_reading(OP_HUM, pick_raw(OP_HUM));
                sent += 3;
            end else begin
                op = 2'($urandom_range(0, 3));
                send_reading(op, pick_raw(op));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        burst_left = 0;
        idle_count = 0;
        gaps_on = 1'b0;
        hold_req = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_reading(OP_PRESS, 20'd415148);
        send_reading(OP_HUM, 20'hFFFFF);
        send_reading(OP_TEMP, 20'd0);
        send_reading(2'd3, 20'hFFFFF);

        load_coeffs(TempStd, PressAStd, PressBStd, PressCStd, HumAStd, HumBStd);
        send_reading(OP_TEMP, 20'd519888);
        send_reading(OP_PRESS, 20'd415148);
        send_reading(OP_HUM, 20'd30000);
        send_reading(OP_PRESS, 20'd0);
        send_reading(OP_PRESS, 20'hFFFFF);
        send_reading(OP_HUM, 20'd0);
        send_reading(OP_HUM, 20'hF_FFFF);
        send_reading(2'd3, 20'd0);
        send_reading(OP_TEMP, 20'hFFFFF);
        send_reading(OP_PRESS, 20'd300000);
        send_reading(OP_HUM, 20'd65535);
        send_reading(OP_TEMP, 20'd0);
        send_reading(OP_HUM, 20'd40000);
        send_reading(OP_PRESS, 20'd500000);

        gaps_on = 1'b1;
        random_readings(90);

        drain();
        hold_req = 1'b1;
        gaps_on = 1'b0;
        random_readings(12);
        gaps_on = 1'b1;

        load_coeffs(TempStd ^ 48'($urandom_range(0, 255)), PressAStd ^ 48'($urandom_range(0, 63)),
                    PressBStd ^ 48'($urandom_range(0, 63)), PressCStd,
                    HumAStd ^ 48'($urandom_range(0, 31)), HumBStd ^ 48'($urandom_range(0, 31)));
        random_readings(90);

        load_coeffs(rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), rnd48());
        random_readings(90);

        load_coeffs({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
        gaps_on = 1'b0;
        random_readings(50);
        gaps_on = 1'b1;

        load_coeffs(48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0);
        random_readings(30);

        load_coeffs(TempStd, {32'd0, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000},
                    {16'h7FFF, 16'h8000, 16'h7FFF}, {8'hFF, 16'h8000, 8'hFF},
                    {8'h80, 16'h7FFF, 16'h8000});
        random_readings(90);

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("env_sensor_compensation_unit_test passed");
        end else begin
            $display("env_sensor_compensation_unit_test failed");
        end
        $finish;
    end

endmodule
